FILE: rtl/core/dtp_pkg.sv
// Shared constants, types and helper functions for the decimal triple parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dtp_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int INT_BITS    = 32;
    localparam int FRAC_BITS   = 16;
    localparam int VAL_W       = 48;

    localparam int IACC_W  = INT_BITS - 1;
    localparam int ISUM_W  = IACC_W + 4;
    localparam int DIV_W   = $clog2(10 ** FRAC_DIGITS);
    localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
    localparam int STEP_W  = $clog2(FRAC_BITS);
    localparam int MAG_W   = IACC_W + FRAC_BITS;
    localparam int WIDE_W  = (MAG_W > VAL_W - 1) ? MAG_W : VAL_W - 1;
    localparam int ADDR_W  = 3;
    localparam int COLOR_MAX = 255;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic [ADDR_W-3:0] REG_COLOR_MODE = '0;

    localparam logic [VAL_W-1:0] COLOR_LIM = VAL_W'(COLOR_MAX) << FRAC_BITS;
    localparam logic [VAL_W-1:0] INT_KEEP  =
        {{(VAL_W - FRAC_BITS){1'b1}}, {FRAC_BITS{1'b0}}};

    localparam logic [31:0] POW10 [10] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000
    };

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef struct packed {
        logic    start_num;
        logic    int_digit;
        logic    frac_digit;
        logic    term_start;
        logic    div_step;
        logic    form_value;
        logic    hold_value;
        logic    hold_sel;
        logic    load_out;
        status_t out_status;
    } dtp_cmd_t;

    typedef struct packed {
        logic is_digit;
        logic is_sign;
        logic is_point;
        logic term_comma;
        logic range_bad;
    } dtp_stat_t;

    function automatic logic [DIV_W-1:0] pow10(input logic [CNT_W-1:0] n);
        pow10 = DIV_W'(POW10[4'(n)]);
    endfunction

    function automatic logic color_ok(input logic [VAL_W-1:0] v);
        color_ok = !v[VAL_W-1] && (v <= COLOR_LIM);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dtp_ifs.sv
// Valid/ready channel interfaces: character input and parsed triple output.
// Depends on dtp_pkg for widths and the status type.
`default_nettype none

interface dtp_char_if;
    import dtp_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface dtp_result_if;
    import dtp_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_z;
    status_t                 status;

    modport source (output valid, output value_x, output value_y, output value_z,
                    output status, input ready);
    modport sink   (input valid, input value_x, input value_y, input value_z,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/decimal_triple_parser.sv
// Decimal triple parser top level: APB register, controller and datapath.
// Depends on dtp_pkg, dtp_ifs (channel interfaces), dtp_ctrl, dtp_datapath.
//
// Usage:
//   chars   : valid/ready channel, one ASCII character per item.
//   results : valid/ready channel, one triple (value_x, value_y, value_z in
//             signed Q31.16, plus status) per finished or failed triple.
//   APB     : register color_mode at byte address 0 (bit 0), read back too.
// Sequence:
//   A digit, sign or '.' that ends no component leaves the controller in
//   S_IDLE, ready for the next item. After the character that ends x or y
//   no item is taken while it passes S_DIV (the bit-serial fraction
//   division by 10^digits, one quotient bit per cycle), S_FORM to form the
//   value and S_DECIDE to decide. After the one that ends z it also passes
//   S_EMIT to load the result; a bad start character goes straight to
//   S_EMIT. The result is held in the output register that S_EMIT loads.
// Stall: the finished result sits in an output register while the next
//   characters are taken; only a second result waits for it to drain.
// Reset: rst_n (async, active low) clears the parse state, drops any
//   pending result and sets color_mode to 0.
`default_nettype none

module decimal_triple_parser (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    dtp_char_if.sink                          chars,
    dtp_result_if.source                      results,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dtp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import dtp_pkg::*;

    logic        color_mode_reg;
    dtp_cmd_t    cmd;
    dtp_stat_t   stat;
    logic [VAL_W-1:0] val_x;
    logic [VAL_W-1:0] val_y;
    logic [VAL_W-1:0] val_z;
    status_t     res_status;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_COLOR_MODE) ? {31'd0, color_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_COLOR_MODE))
        begin
            color_mode_reg <= pwdata[0];
        end
    end

    dtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chars.valid),
        .in_ready  (chars.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dtp_datapath u_datapath (
        .clk        (clk),
        .color_mode (color_mode_reg),
        .char_code  (chars.char_code),
        .cmd        (cmd),
        .stat       (stat),
        .value_x    (val_x),
        .value_y    (val_y),
        .value_z    (val_z),
        .status     (res_status)
    );

    assign results.value_x = val_x;
    assign results.value_y = val_y;
    assign results.value_z = val_z;
    assign results.status  = res_status;

endmodule

`default_nettype wire

FILE: rtl/core/dtp_datapath.sv
// Datapath: character decode, accumulators, bit-serial fraction divider,
// value forming, held components and output register. Uses dtp_pkg.
`default_nettype none

module dtp_datapath (
    input  wire logic                    clk,
    input  wire logic                    color_mode,
    input  wire logic [7:0]              char_code,
    input  wire dtp_pkg::dtp_cmd_t       cmd,
    output dtp_pkg::dtp_stat_t           stat,
    output logic [dtp_pkg::VAL_W-1:0]    value_x,
    output logic [dtp_pkg::VAL_W-1:0]    value_y,
    output logic [dtp_pkg::VAL_W-1:0]    value_z,
    output dtp_pkg::status_t             status
);
    import dtp_pkg::*;

    logic              neg_reg;
    logic [IACC_W-1:0] int_acc_reg;
    logic [DIV_W-1:0]  frac_acc_reg;
    logic [CNT_W-1:0]  frac_cnt_reg;
    logic              comma_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [VAL_W-1:0]  held_reg [2];
    logic [VAL_W-1:0]  out_x_reg;
    logic [VAL_W-1:0]  out_y_reg;
    logic [VAL_W-1:0]  out_z_reg;
    status_t           out_status_reg;

    logic                is_digit;
    logic [7:0]          digit_ofs;
    logic [3:0]          digit;
    logic [ISUM_W-1:0]   int_sum;
    logic [IACC_W-1:0]   int_next;
    logic [DIV_W+3:0]    frac_sum;
    logic [DIV_W:0]      trial;
    logic [DIV_W:0]      diff;
    logic                fits;
    logic [DIV_W-1:0]    rem_next;
    logic [WIDE_W-1:0]   mag_wide;
    logic [VAL_W-2:0]    mag;
    logic [VAL_W-1:0]    value_next;
    logic [VAL_W-1:0]    keep;

    always_comb
    begin
        is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        digit_ofs = char_code - CH_ZERO;
        digit     = is_digit ? digit_ofs[3:0] : 4'd0;

        // integer *10 + d, saturate at the largest positive magnitude
        int_sum  = (ISUM_W'(int_acc_reg) << 3) + (ISUM_W'(int_acc_reg) << 1)
                 + ISUM_W'(digit);
        int_next = (int_sum > ISUM_W'({IACC_W{1'b1}})) ? {IACC_W{1'b1}}
                                                       : int_sum[IACC_W-1:0];
        frac_sum = ((DIV_W + 4)'(frac_acc_reg) << 3) + ((DIV_W + 4)'(frac_acc_reg) << 1)
                 + (DIV_W + 4)'(digit);

        // one restoring-division step: remainder stays below the divisor
        trial    = {rem_reg, 1'b0};
        fits     = trial >= {1'b0, div_reg};
        diff     = trial - {1'b0, div_reg};
        rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

        mag_wide = (WIDE_W'(int_acc_reg) << FRAC_BITS) | WIDE_W'(quo_reg);
        mag      = (mag_wide > WIDE_W'({(VAL_W - 1){1'b1}})) ? {(VAL_W - 1){1'b1}}
                                                            : mag_wide[VAL_W-2:0];
        value_next = neg_reg ? (VAL_W'(0) - {1'b0, mag}) : {1'b0, mag};

        keep = color_mode ? INT_KEEP : {VAL_W{1'b1}};

        stat.is_digit   = is_digit;
        stat.is_sign    = (char_code == CH_MINUS) || (char_code == CH_PLUS);
        stat.is_point   = (char_code == CH_POINT);
        stat.term_comma = comma_reg;
        stat.range_bad  = color_mode && !(color_ok(held_reg[0]) && color_ok(held_reg[1])
                                          && color_ok(value_reg));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_num)
        begin
            neg_reg      <= (char_code == CH_MINUS);
            int_acc_reg  <= IACC_W'(digit);
            frac_acc_reg <= '0;
            frac_cnt_reg <= '0;
        end
        if (cmd.int_digit)
        begin
            int_acc_reg <= int_next;
        end
        // drop fraction digits past the kept precision
        if (cmd.frac_digit && (frac_cnt_reg < CNT_W'(FRAC_DIGITS)))
        begin
            frac_acc_reg <= frac_sum[DIV_W-1:0];
            frac_cnt_reg <= frac_cnt_reg + CNT_W'(1);
        end
        if (cmd.term_start)
        begin
            comma_reg <= (char_code == CH_COMMA);
            rem_reg   <= frac_acc_reg;
            div_reg   <= pow10(frac_cnt_reg);
            quo_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[FRAC_BITS-2:0], fits};
        end
        if (cmd.form_value)
        begin
            value_reg <= value_next;
        end
        if (cmd.hold_value)
        begin
            held_reg[cmd.hold_sel] <= value_reg;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            if (cmd.out_status == ST_OK)
            begin
                out_x_reg <= held_reg[0] & keep;
                out_y_reg <= held_reg[1] & keep;
                out_z_reg <= value_reg & keep;
            end
            else
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
            end
        end
    end

    assign value_x = out_x_reg;
    assign value_y = out_y_reg;
    assign value_z = out_z_reg;
    assign status  = out_status_reg;

endmodule

`default_nettype wire

FILE: rtl/core/dtp_ctrl.sv
// Controller: parse phase, component index, divider sequencing and output
// valid. Drives the datapath through dtp_cmd_t; uses dtp_pkg.
`default_nettype none

module dtp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire dtp_pkg::dtp_stat_t stat,
    output dtp_pkg::dtp_cmd_t   cmd
);
    import dtp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FORM,
        S_DECIDE,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC
    } phase_t;

    localparam logic [1:0] LAST_COMP = 2'd2;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [1:0]        comp_reg, comp_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    status_t           emit_status_reg, emit_status_next;
    logic              accept;

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        comp_next        = comp_reg;
        step_next        = step_reg;
        emit_status_next = emit_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        cmd              = '0;
        cmd.out_status   = emit_status_reg;
        cmd.hold_sel     = comp_reg[0];
        in_ready         = (state_reg == S_IDLE);
        accept           = in_valid && in_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_START:
                        begin
                            if (stat.is_digit || stat.is_sign)
                            begin
                                cmd.start_num = 1'b1;
                                phase_next    = PH_INT;
                            end
                            else
                            begin
                                emit_status_next = ST_FORMAT;
                                state_next       = S_EMIT;
                            end
                        end
                        PH_INT:
                        begin
                            if (stat.is_digit)
                            begin
                                cmd.int_digit = 1'b1;
                            end
                            else if (stat.is_point)
                            begin
                                phase_next = PH_FRAC;
                            end
                            else
                            begin
                                cmd.term_start = 1'b1;
                                step_next      = STEP_W'(FRAC_BITS - 1);
                                state_next     = S_DIV;
                            end
                        end
                        PH_FRAC:
                        begin
                            if (stat.is_digit)
                            begin
                                cmd.frac_digit = 1'b1;
                            end
                            else
                            begin
                                cmd.term_start = 1'b1;
                                step_next      = STEP_W'(FRAC_BITS - 1);
                                state_next     = S_DIV;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_START;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_FORM;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            S_FORM:
            begin
                cmd.form_value = 1'b1;
                state_next     = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (comp_reg < LAST_COMP)
                begin
                    if (stat.term_comma)
                    begin
                        cmd.hold_value = 1'b1;
                        comp_next      = comp_reg + 2'd1;
                        phase_next     = PH_START;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        emit_status_next = ST_FORMAT;
                        state_next       = S_EMIT;
                    end
                end
                else
                begin
                    emit_status_next = stat.range_bad ? ST_RANGE : ST_OK;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // wait for a free output register, then restart at x
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    comp_next      = '0;
                    phase_next     = PH_START;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_START;
            comp_reg        <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
            emit_status_reg <= ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            comp_reg        <= comp_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
            emit_status_reg <= emit_status_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register loaded while a result is still waiting");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == '0) |=> (state_reg == S_FORM))
        else $error("divider did not finish after its last step");

    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        comp_reg != 2'd3)
        else $error("component index out of range");

    a_hold_only_xy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hold_value |-> (comp_reg < LAST_COMP && $past(state_reg) == S_FORM))
        else $error("component held outside of x or y");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for decimal_triple_parser: drives characters, APB writes of
// color_mode and random stalls, and checks every triple against an in-bench predictor.
// Depends on dtp_pkg, dtp_ifs and the decimal_triple_parser RTL.
`timescale 1ns / 1ps

module tb;
    import dtp_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [VAL_W-1:0] z;
        status_t          st;
    } triple_t;

    typedef struct {
        string      text;
        logic [7:0] last;
        bit         color;
        bit         typed;
        triple_t    want;
    } dir_row_t;

    typedef enum logic [1:0] {
        EXPECT_START,
        INT_PART,
        FRAC_PART
    } num_phase_t;

    localparam logic [ADDR_W-1:0] ADDR_COLOR = {REG_COLOR_MODE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE = {~REG_COLOR_MODE, 2'b00};
    localparam logic [63:0] INT_SAT = (64'd1 << (INT_BITS - 1)) - 64'd1;
    localparam logic [63:0] MAG_SAT = (64'd1 << (VAL_W - 1)) - 64'd1;
    localparam logic [VAL_W-1:0] BYTE_TOP = VAL_W'(COLOR_MAX) << FRAC_BITS;
    localparam logic [VAL_W-1:0] WHOLE_MASK = ~((VAL_W'(1) << FRAC_BITS) - VAL_W'(1));

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dtp_char_if   chars_if ();
    dtp_result_if results_if ();

    decimal_triple_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    bit               color_sel;
    int               comp_idx;
    num_phase_t       num_phase;
    bit               neg;
    logic [63:0]      int_mag;
    logic [63:0]      frac_acc;
    int               frac_cnt;
    logic [VAL_W-1:0] held [2];

    triple_t    triples_due [$];
    logic [7:0] text_q [$];
    int         idle_pct;
    int         stall_pct;
    int         mismatches;

    function automatic bit in_byte_range(input logic [VAL_W-1:0] v);
        return !v[VAL_W-1] && (v <= BYTE_TOP);
    endfunction

    task automatic parse_char(input logic [7:0] c, output bit done, output triple_t r);
        bit               dig;
        bit               ends;
        logic [63:0]      d;
        logic [63:0]      mag;
        logic [63:0]      div;
        logic [VAL_W-1:0] v;
        dig  = (c >= CH_ZERO) && (c <= CH_NINE);
        d    = dig ? 64'(c - CH_ZERO) : 64'd0;
        done = 1'b0;
        ends = 1'b0;
        r    = '{'0, '0, '0, ST_OK};
        if (num_phase == EXPECT_START)
        begin
            if (!dig && c != CH_MINUS && c != CH_PLUS)
            begin
                r.st = ST_FORMAT;
                done = 1'b1;
            end
            else
            begin
                neg       = (c == CH_MINUS);
                int_mag   = d;
                frac_acc  = '0;
                frac_cnt  = 0;
                num_phase = INT_PART;
            end
        end
        else if (num_phase == INT_PART)
        begin
            if (dig)
            begin
                int_mag = int_mag * 10 + d;
                if (int_mag > INT_SAT)
                    int_mag = INT_SAT;
            end
            else if (c == CH_POINT)
                num_phase = FRAC_PART;
            else
                ends = 1'b1;
        end
        else if (dig)
        begin
            // digits past the kept count are swallowed
            if (frac_cnt < FRAC_DIGITS)
            begin
                frac_acc = frac_acc * 10 + d;
                frac_cnt++;
            end
        end
        else
            ends = 1'b1;

        if (ends)
        begin
            div = 64'd1;
            repeat (frac_cnt) div = div * 10;
            mag = (int_mag << FRAC_BITS) + ((frac_acc << FRAC_BITS) / div);
            if (mag > MAG_SAT)
                mag = MAG_SAT;
            if (neg)
                mag = -mag;
            v = mag[VAL_W-1:0];
            if (comp_idx < 2)
            begin
                if (c != CH_COMMA)
                begin
                    r.st = ST_FORMAT;
                    done = 1'b1;
                end
                else
                begin
                    held[comp_idx] = v;
                    comp_idx++;
                    num_phase = EXPECT_START;
                end
            end
            else
            begin
                done = 1'b1;
                if (!color_sel)
                    r = '{held[0], held[1], v, ST_OK};
                else if (!in_byte_range(held[0]) || !in_byte_range(held[1])
                         || !in_byte_range(v))
                    r.st = ST_RANGE;
                else
                    r = '{held[0] & WHOLE_MASK, held[1] & WHOLE_MASK, v & WHOLE_MASK, ST_OK};
            end
        end

        if (done)
        begin
            comp_idx  = 0;
            num_phase = EXPECT_START;
            neg       = 1'b0;
            int_mag   = '0;
            frac_acc  = '0;
            frac_cnt  = 0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_triple();
        triple_t want;
        if (triples_due.size() == 0)
        begin
            report_mismatch("result with nothing expected");
            return;
        end
        want = triples_due.pop_front();
        if (results_if.value_x !== want.x)
            report_mismatch($sformatf("value_x got %h want %h", results_if.value_x, want.x));
        if (results_if.value_y !== want.y)
            report_mismatch($sformatf("value_y got %h want %h", results_if.value_y, want.y));
        if (results_if.value_z !== want.z)
            report_mismatch($sformatf("value_z got %h want %h", results_if.value_z, want.z));
        if (results_if.status !== want.st)
            report_mismatch($sformatf("status got %0d want %0d", results_if.status, want.st));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
                check_triple();
            results_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_char(input logic [7:0] c, input bit given_ok, input triple_t given);
        bit      done;
        triple_t r;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            chars_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        do @(posedge clk); while (!chars_if.ready);
        parse_char(c, done, r);
        if (done)
            triples_due.push_back(given_ok ? given : r);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[ADDR_W-1:2] == REG_COLOR_MODE)
            color_sel = data[0];
    endtask

    // drain, let a number still being closed finish, then write
    task automatic set_color(input bit mode);
        chars_if.valid <= 1'b0;
        while (triples_due.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
        apb_write(ADDR_COLOR, {31'($urandom_range(32'h7FFF_FFFF)), mode});
    endtask

    task automatic add_number(input bit near_byte);
        int    kind;
        int    len;
        int    flen;
        string s;
        kind = $urandom_range(99);
        if (kind < 12)
            text_q.push_back(CH_MINUS);
        else if (kind < 20)
            text_q.push_back(CH_PLUS);
        if (near_byte)
        begin
            // hover around the top of the byte range
            s = $sformatf("%0d", ($urandom_range(3) == 0) ? $urandom_range(250, 260)
                                                          : $urandom_range(0, 300));
            for (int i = 0; i < s.len(); i++)
                text_q.push_back(s[i]);
        end
        else
        begin
            len = ($urandom_range(99) < 6) ? $urandom_range(9, 14) : $urandom_range(0, 4);
            repeat (len) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(1))
        begin
            text_q.push_back(CH_POINT);
            flen = ($urandom_range(99) < 10) ? $urandom_range(6, 9) : $urandom_range(0, 3);
            repeat (flen) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
        end
    endtask

    task automatic run_phase(input int n_items, input int idle, input int stall, input bit mode);
        int         sent;
        logic [7:0] t;
        set_color(mode);
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < n_items)
        begin
            text_q.delete();
            if ($urandom_range(99) < 8)
            begin
                repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    add_number(mode && $urandom_range(9) != 0);
                    if (k < 2)
                        text_q.push_back(($urandom_range(99) < 4) ? 8'($urandom_range(255))
                                                                  : CH_COMMA);
                end
                do t = 8'($urandom_range(255));
                while ((t >= CH_ZERO && t <= CH_NINE) || t == CH_POINT);
                text_q.push_back(t);
            end
            foreach (text_q[i])
                send_char(text_q[i], 1'b0, '0);
            sent += text_q.size();
        end
    endtask

    dir_row_t plan [4];

    initial
    begin
        rst_n               = 1'b0;
        chars_if.valid      = 1'b0;
        chars_if.char_code  = '0;
        results_if.ready    = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        idle_pct            = 0;
        stall_pct           = 0;
        mismatches          = 0;
        color_sel           = 1'b0;
        comp_idx            = 0;
        num_phase           = EXPECT_START;
        neg                 = 1'b0;
        int_mag             = '0;
        frac_acc            = '0;
        frac_cnt            = 0;
        held[0]             = '0;
        held[1]             = '0;

        // bad start on the top code, bad separator, then signs, empty parts,
        // leading zeros, a long fraction and a second point, then colour on
        // with negative zero, the exact top value and a NUL to end z
        plan[0] = '{"", 8'hFF, 1'b0, 1'b1, '{'0, '0, '0, ST_FORMAT}};
        plan[1] = '{"1", 8'h3B, 1'b0, 1'b1, '{'0, '0, '0, ST_FORMAT}};
        plan[2] = '{"-,+.05,1.1234567", CH_POINT, 1'b0, 1'b0, '0};
        plan[3] = '{"-0,255,2", 8'h00, 1'b1, 1'b1,
                    '{48'h0000_0000_0000, 48'h0000_00FF_0000, 48'h0000_0002_0000, ST_OK}};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // an unmapped index must leave colour mode off
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        foreach (plan[i])
        begin
            if (plan[i].color != color_sel)
                set_color(plan[i].color);
            for (int j = 0; j < plan[i].text.len(); j++)
                send_char(plan[i].text[j], 1'b0, '0);
            send_char(plan[i].last, plan[i].typed, plan[i].want);
        end

        run_phase(450, 0, 0, 1'b0);
        run_phase(450, 88, 0, 1'b1);
        run_phase(450, 0, 88, 1'b0);
        run_phase(450, 31, 31, 1'b1);

        chars_if.valid <= 1'b0;
        while (triples_due.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
